>>> hdl/alert_pattern_sequencer_defines.svh
// assertion macros for the port-level checker file
`ifndef ALERT_PATTERN_SEQUENCER_DEFINES_SVH
`define ALERT_PATTERN_SEQUENCER_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define APS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous active-low reset
`define APS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/aps_pkg.sv
// types, codes and timing constants of the alert pattern sequencer
package aps_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_STOP = 2'd2
  } mode_t;

  // alert pattern codes
  typedef enum logic [2:0] {
    PAT_NONE       = 3'd0,
    PAT_SHORT_BEEP = 3'd1,
    PAT_DOUBLE     = 3'd2,
    PAT_LONG_BEEP  = 3'd3,
    PAT_LED_ON     = 3'd4,
    PAT_SLOW_BLINK = 3'd5,
    PAT_FAST_BLINK = 3'd6,
    PAT_BEEP_BLINK = 3'd7
  } pattern_t;

  localparam int unsigned TimeW = 32;

  // pattern timing in milliseconds
  localparam logic [TimeW-1:0] SHORT_BEEP_MS = 32'd100;
  localparam logic [TimeW-1:0] LONG_BEEP_MS  = 32'd500;
  localparam logic [TimeW-1:0] DOUBLE_STEP1  = 32'd100;
  localparam logic [TimeW-1:0] DOUBLE_STEP2  = 32'd200;
  localparam logic [TimeW-1:0] DOUBLE_STEP3  = 32'd300;

  // reciprocals for exact floor division: x/125 for x < 2^31, x/25 for x < 2^30
  localparam logic [31:0] RECIP_125 = 32'd2199023256;
  localparam int unsigned SHIFT_125 = 38;
  localparam logic [31:0] RECIP_25  = 32'd1374389535;
  localparam int unsigned SHIFT_25  = 35;

  // one input item
  typedef struct packed {
    mode_t            mode;
    logic [3:0]       pattern;
    logic [TimeW-1:0] now_time;
  } item_t;

  // one result item
  typedef struct packed {
    logic buzzer_on;
    logic led_on;
    logic busy;
  } result_t;

  // elapsed-time flags for the pattern logic
  typedef struct packed {
    logic lt_step1;
    logic lt_step2;
    logic lt_step3;
    logic lt_long;
    logic half_on;
  } phase_t;

endpackage

>>> hdl/aps_phase.sv
// elapsed-time compares and blink half-period parity
module aps_phase (
  input  logic [aps_pkg::TimeW-1:0] elapsed,
  input  aps_pkg::pattern_t         pat,
  output aps_pkg::phase_t           phase
);
  import aps_pkg::*;

  logic [30:0] div_x;
  logic [31:0] div_m;
  logic [62:0] prod;
  logic        q_odd;

  // threshold compares for the one-shot patterns
  assign phase.lt_step1 = (elapsed < DOUBLE_STEP1);
  assign phase.lt_step2 = (elapsed < DOUBLE_STEP2);
  assign phase.lt_step3 = (elapsed < DOUBLE_STEP3);
  assign phase.lt_long  = (elapsed < LONG_BEEP_MS);

  // t/250 = (t>>1)/125, t/500 = (t>>2)/125, t/100 = (t>>2)/25
  always_comb begin
    div_x = {1'b0, elapsed[TimeW-1:2]};
    div_m = RECIP_125;
    if (pat == PAT_BEEP_BLINK) begin
      div_x = elapsed[TimeW-1:1];
    end
    if (pat == PAT_FAST_BLINK) begin
      div_m = RECIP_25;
    end
  end

  // one shared reciprocal multiply, only the quotient parity is kept
  assign prod  = 63'(div_x) * 63'(div_m);
  assign q_odd = (pat == PAT_FAST_BLINK) ? prod[SHIFT_25] : prod[SHIFT_125];
  assign phase.half_on = ~q_odd;

endmodule

>>> hdl/aps_ctrl.sv
// pattern state registers and per-item update
module aps_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  aps_pkg::item_t  item,
  output aps_pkg::result_t res
);
  import aps_pkg::*;

  pattern_t         pat_r, pat_nxt;
  logic             seeded_r, seeded_nxt;
  logic [TimeW-1:0] base_r, base_nxt;
  logic             buz_r, buz_nxt;
  logic             led_r, led_nxt;
  logic [TimeW-1:0] elapsed;
  phase_t           phase;

  // elapsed time, zero on the tick that seeds the base
  assign elapsed = seeded_r ? (item.now_time - base_r) : '0;

  aps_phase u_phase (
    .elapsed (elapsed),
    .pat     (pat_r),
    .phase   (phase)
  );

  // next state for the item in the input register
  always_comb begin
    pat_nxt    = pat_r;
    seeded_nxt = seeded_r;
    base_nxt   = base_r;
    buz_nxt    = buz_r;
    led_nxt    = led_r;
    case (item.mode)
      MODE_TICK: begin
        if (pat_r != PAT_NONE) begin
          seeded_nxt = 1'b1;
          base_nxt   = seeded_r ? base_r : item.now_time;
          case (pat_r)
            PAT_SHORT_BEEP: begin
              if (phase.lt_step1) begin
                buz_nxt = 1'b1;
              end else begin
                pat_nxt    = PAT_NONE;
                seeded_nxt = 1'b0;
                buz_nxt    = 1'b0;
                led_nxt    = 1'b0;
              end
            end
            PAT_DOUBLE: begin
              if (phase.lt_step3) begin
                buz_nxt = phase.lt_step1 || !phase.lt_step2;
              end else begin
                pat_nxt    = PAT_NONE;
                seeded_nxt = 1'b0;
                buz_nxt    = 1'b0;
                led_nxt    = 1'b0;
              end
            end
            PAT_LONG_BEEP: begin
              if (phase.lt_long) begin
                buz_nxt = 1'b1;
              end else begin
                pat_nxt    = PAT_NONE;
                seeded_nxt = 1'b0;
                buz_nxt    = 1'b0;
                led_nxt    = 1'b0;
              end
            end
            PAT_LED_ON: begin
              led_nxt = 1'b1;
            end
            PAT_SLOW_BLINK, PAT_FAST_BLINK: begin
              led_nxt = phase.half_on;
            end
            PAT_BEEP_BLINK: begin
              buz_nxt = phase.half_on;
              led_nxt = phase.half_on;
            end
            default: begin
            end
          endcase
        end
      end
      MODE_PLAY: begin
        seeded_nxt = 1'b0;
        buz_nxt    = 1'b0;
        led_nxt    = 1'b0;
        // codes 8..15 select none
        pat_nxt    = item.pattern[3] ? PAT_NONE : pattern_t'(item.pattern[2:0]);
      end
      MODE_STOP: begin
        pat_nxt    = PAT_NONE;
        seeded_nxt = 1'b0;
        buz_nxt    = 1'b0;
        led_nxt    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // result reflects the state after this item
  assign res.buzzer_on = buz_nxt;
  assign res.led_on    = led_nxt;
  assign res.busy      = (pat_nxt != PAT_NONE);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r    <= PAT_NONE;
      seeded_r <= 1'b0;
      base_r   <= '0;
      buz_r    <= 1'b0;
      led_r    <= 1'b0;
    end else if (step) begin
      pat_r    <= pat_nxt;
      seeded_r <= seeded_nxt;
      base_r   <= base_nxt;
      buz_r    <= buz_nxt;
      led_r    <= led_nxt;
    end
  end

endmodule

>>> hdl/alert_pattern_sequencer.sv
// an accepted item waits in the input register; its result is registered in the result register when it advances
// throughput: one item per cycle while out_ready drains the result, set by the single input and result register pair
// the state update and the shared reciprocal multiply sit between those registers
// a held result does not block acceptance while the input register is free
// reset (rst_n low, synchronous): pattern none, buzzer and LED state off, both channels empty
module alert_pattern_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_pattern,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_buzzer_on,
  output logic        out_led_on,
  output logic        out_busy_res
);
  import aps_pkg::*;

  logic    s0_vld_r;
  item_t   s0_item_r;
  logic    out_vld_r;
  result_t out_res_r;
  result_t res;
  logic    advance;

  // item moves into the result register when that register is free or drained
  assign advance  = s0_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s0_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ready) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item_r.mode     <= mode_t'(in_mode);
      s0_item_r.pattern  <= in_pattern;
      s0_item_r.now_time <= in_now_time;
    end
  end

  aps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s0_item_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_buzzer_on = out_res_r.buzzer_on;
  assign out_led_on    = out_res_r.led_on;
  assign out_busy_res  = out_res_r.busy;

endmodule

>>> hdl/aps_checker.sv
// port-level checks for the alert pattern sequencer, bound to the top level
`include "alert_pattern_sequencer_defines.svh"

module aps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic [3:0]  in_pattern,
  input logic [31:0] in_now_time,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_buzzer_on,
  input logic        out_led_on,
  input logic        out_busy_res
);

  // a stalled result stays offered
  `APS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a stalled result keeps its levels
  `APS_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_buzzer_on) && $stable(out_led_on) && $stable(out_busy_res), "result changed while stalled")

  // with no pattern active both outputs are silent
  `APS_ASSERT_IMP(a_idle_silent, clk, rst_n, out_valid && !out_busy_res, !out_buzzer_on && !out_led_on, "output driven with no active pattern")

  // an empty result side never blocks the input
  `APS_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid, in_ready, "input blocked with empty result register")

endmodule

bind alert_pattern_sequencer aps_checker u_aps_checker (.*);
